@@ rtl/i2cmts_pkg.sv @@
package i2cmts_pkg;

  localparam int unsigned BufferDepth = 32;
  localparam int unsigned AddrW = (BufferDepth > 1) ? $clog2(BufferDepth) : 1;
  localparam int unsigned CountW = $clog2(BufferDepth + 1);

  // bus status codes, low three bits masked off
  localparam logic [7:0] StatusMask  = 8'hF8;
  localparam logic [7:0] StStart     = 8'h08;
  localparam logic [7:0] StRepStart  = 8'h10;
  localparam logic [7:0] StSlaWAck   = 8'h18;
  localparam logic [7:0] StSlaWNack  = 8'h20;
  localparam logic [7:0] StDataWAck  = 8'h28;
  localparam logic [7:0] StDataWNack = 8'h30;
  localparam logic [7:0] StArbLost   = 8'h38;
  localparam logic [7:0] StSlaRAck   = 8'h40;
  localparam logic [7:0] StSlaRNack  = 8'h48;
  localparam logic [7:0] StDataRAck  = 8'h50;
  localparam logic [7:0] StDataRNack = 8'h58;

  typedef enum logic [2:0] {
    OpLoad       = 3'd0,
    OpStartRead  = 3'd1,
    OpStartWrite = 3'd2,
    OpStatus     = 3'd3,
    OpPop        = 3'd4
  } op_e;

  typedef enum logic [2:0] {
    ActNone    = 3'd0,
    ActStart   = 3'd1,
    ActAck     = 3'd2,
    ActNack    = 3'd3,
    ActStop    = 3'd4,
    ActRelease = 3'd5
  } act_e;

  typedef enum logic [1:0] {
    ErrNone = 2'd0,
    ErrArb  = 2'd1,
    ErrNack = 2'd2
  } err_e;

  typedef enum logic [2:0] {
    PhReady = 3'b001,
    PhRead  = 3'b010,
    PhWrite = 3'b100
  } phase_e;

  typedef struct packed {
    logic [2:0] operation;
    logic [6:0] slave_addr;
    logic [5:0] byte_count;
    logic [4:0] load_index;
    logic [7:0] load_byte;
    logic [7:0] bus_status;
    logic [7:0] rx_byte;
  } item_t;

  typedef struct packed {
    logic [2:0] bus_action;
    logic [7:0] tx_value;
    logic       tx_valid;
    logic       busy_res;
    logic [1:0] error_code;
    logic [7:0] popped_byte;
    logic [5:0] bytes_available;
  } result_t;

  // decision of one item, data bytes from the store still to be merged
  typedef struct packed {
    result_t res;
    logic    tx_from_mem;
    logic    pop_from_mem;
  } decision_t;

  typedef struct packed {
    logic             we;
    logic [AddrW-1:0] waddr;
    logic [7:0]       wdata;
    logic             re;
    logic [AddrW-1:0] raddr;
  } mem_req_t;

endpackage

@@ rtl/i2c_master_transfer_sequencer.sv @@
// an item's decision is registered in the first stage, then its result in the output
// register, which offers it; a stall at the output holds the result there
// throughput: one item per cycle while output is free; send/pop reads set the 2 stages
// the store has one write and one registered read port
// reset clears the phase, counters, error and handshake state at once
// store contents are undefined until loaded or received
module i2c_master_transfer_sequencer (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  i2cmts_pkg::item_t   in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output i2cmts_pkg::result_t out_item_o
);

  logic                  accept;
  logic                  s1_advance;
  logic                  s1_valid_q;
  i2cmts_pkg::decision_t s1_dec_q;
  i2cmts_pkg::decision_t dec;
  i2cmts_pkg::mem_req_t  mem;
  logic [7:0]            rdata;
  i2cmts_pkg::result_t   res_d;
  i2cmts_pkg::result_t   out_item_q;
  logic                  out_valid_q;

  assign s1_advance = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_advance;
  assign accept     = in_valid_i && in_ready_o;

  i2cmts_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .item_i   (in_item_i),
    .dec_o    (dec),
    .mem_o    (mem)
  );

  i2cmts_ram #(
    .Width (8),
    .Depth (i2cmts_pkg::BufferDepth)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem.we),
    .waddr_i (mem.waddr),
    .wdata_i (mem.wdata),
    .re_i    (mem.re),
    .raddr_i (mem.raddr),
    .rdata_o (rdata)
  );

  // merge the store byte into the result
  always_comb begin
    res_d = s1_dec_q.res;
    if (s1_dec_q.tx_from_mem) begin
      res_d.tx_value = rdata;
    end
    res_d.popped_byte = s1_dec_q.pop_from_mem ? rdata : 8'd0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid_q <= 1'b1;
      end else if (s1_advance) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_advance) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_dec_q <= dec;
    end
    if (s1_advance) begin
      out_item_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

@@ rtl/i2cmts_ram.sv @@
module i2cmts_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 32
) (
  input  logic                                        clk_i,
  input  logic                                        we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                            wdata_i,
  input  logic                                        re_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                            rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/i2cmts_ctrl.sv @@
module i2cmts_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  accept_i,
  input  i2cmts_pkg::item_t     item_i,
  output i2cmts_pkg::decision_t dec_o,
  output i2cmts_pkg::mem_req_t  mem_o
);

  i2cmts_pkg::phase_e                phase_q, phase_d;
  logic [7:0]                        target_q, target_d;
  logic [i2cmts_pkg::CountW-1:0]     len_q, len_d;
  logic [i2cmts_pkg::CountW-1:0]     sp_q, sp_d;
  logic                              last_q, last_d;
  logic [i2cmts_pkg::CountW-1:0]     rc_q, rc_d;
  logic [i2cmts_pkg::CountW-1:0]     pop_q, pop_d;
  i2cmts_pkg::err_e                  err_q, err_d;
  logic [7:0]                        status;
  i2cmts_pkg::decision_t             dec;
  i2cmts_pkg::mem_req_t              mem;

  always_comb begin
    phase_d  = phase_q;
    target_d = target_q;
    len_d    = len_q;
    sp_d     = sp_q;
    last_d   = last_q;
    rc_d     = rc_q;
    pop_d    = pop_q;
    err_d    = err_q;
    dec      = '0;
    mem      = '0;
    dec.res.bus_action = i2cmts_pkg::ActNone;
    status   = item_i.bus_status & i2cmts_pkg::StatusMask;

    case (item_i.operation)
      i2cmts_pkg::OpLoad: begin
        if (32'(item_i.load_index) < i2cmts_pkg::BufferDepth) begin
          mem.we    = 1'b1;
          mem.waddr = i2cmts_pkg::AddrW'(item_i.load_index);
          mem.wdata = item_i.load_byte;
        end
      end
      i2cmts_pkg::OpStartRead, i2cmts_pkg::OpStartWrite: begin
        if (phase_q == i2cmts_pkg::PhReady) begin
          if (item_i.byte_count == '0) begin
            len_d = i2cmts_pkg::CountW'(1);
          end else if (32'(item_i.byte_count) > i2cmts_pkg::BufferDepth) begin
            len_d = i2cmts_pkg::CountW'(i2cmts_pkg::BufferDepth);
          end else begin
            len_d = i2cmts_pkg::CountW'(item_i.byte_count);
          end
          err_d = i2cmts_pkg::ErrNone;
          if (item_i.operation == i2cmts_pkg::OpStartRead) begin
            rc_d     = '0;
            pop_d    = '0;
            phase_d  = i2cmts_pkg::PhRead;
            target_d = {item_i.slave_addr, 1'b1};
          end else begin
            sp_d     = '0;
            last_d   = 1'b0;
            phase_d  = i2cmts_pkg::PhWrite;
            target_d = {item_i.slave_addr, 1'b0};
          end
          dec.res.bus_action = i2cmts_pkg::ActStart;
        end
      end
      i2cmts_pkg::OpStatus: begin
        if (phase_q != i2cmts_pkg::PhReady) begin
          case (status)
            i2cmts_pkg::StStart, i2cmts_pkg::StRepStart: begin
              dec.res.tx_value   = target_q;
              dec.res.tx_valid   = 1'b1;
              dec.res.bus_action = i2cmts_pkg::ActAck;
            end
            i2cmts_pkg::StArbLost: begin
              err_d   = i2cmts_pkg::ErrArb;
              phase_d = i2cmts_pkg::PhReady;
              dec.res.bus_action = i2cmts_pkg::ActRelease;
            end
            i2cmts_pkg::StSlaRAck: begin
              // last byte of the transfer gets a nack
              dec.res.bus_action = (({1'b0, rc_q} + 1'b1) < {1'b0, len_q}) ?
                                   i2cmts_pkg::ActAck : i2cmts_pkg::ActNack;
            end
            i2cmts_pkg::StSlaRNack, i2cmts_pkg::StSlaWNack,
            i2cmts_pkg::StDataWNack: begin
              err_d   = i2cmts_pkg::ErrNack;
              phase_d = i2cmts_pkg::PhReady;
              dec.res.bus_action = i2cmts_pkg::ActStop;
            end
            i2cmts_pkg::StDataRAck, i2cmts_pkg::StDataRNack: begin
              // byte dropped when the store is full
              if (32'(rc_q) < i2cmts_pkg::BufferDepth) begin
                mem.we    = 1'b1;
                mem.waddr = i2cmts_pkg::AddrW'(rc_q);
                mem.wdata = item_i.rx_byte;
                rc_d      = rc_q + 1'b1;
              end
              if (status == i2cmts_pkg::StDataRAck) begin
                dec.res.bus_action = (({1'b0, rc_d} + 1'b1) < {1'b0, len_q}) ?
                                     i2cmts_pkg::ActAck : i2cmts_pkg::ActNack;
              end else begin
                phase_d = i2cmts_pkg::PhReady;
                dec.res.bus_action = i2cmts_pkg::ActStop;
              end
            end
            i2cmts_pkg::StSlaWAck, i2cmts_pkg::StDataWAck: begin
              if (sp_q < len_q && !last_q &&
                  32'(sp_q) < i2cmts_pkg::BufferDepth) begin
                mem.re          = 1'b1;
                mem.raddr       = i2cmts_pkg::AddrW'(sp_q);
                dec.tx_from_mem = 1'b1;
                dec.res.tx_valid = 1'b1;
                if (({1'b0, sp_q} + 1'b1) < {1'b0, len_q}) begin
                  sp_d = sp_q + 1'b1;
                end else begin
                  last_d = 1'b1;
                end
                dec.res.bus_action = i2cmts_pkg::ActAck;
              end else begin
                phase_d = i2cmts_pkg::PhReady;
                dec.res.bus_action = i2cmts_pkg::ActStop;
              end
            end
            default: begin
            end
          endcase
        end
      end
      i2cmts_pkg::OpPop: begin
        if (pop_q < rc_q && 32'(pop_q) < i2cmts_pkg::BufferDepth) begin
          mem.re           = 1'b1;
          mem.raddr        = i2cmts_pkg::AddrW'(pop_q);
          dec.pop_from_mem = 1'b1;
          pop_d            = pop_q + 1'b1;
        end
      end
      default: begin
      end
    endcase

    dec.res.busy_res   = (phase_d != i2cmts_pkg::PhReady);
    dec.res.error_code = err_d;
    dec.res.bytes_available = (rc_d >= pop_d) ? 6'(rc_d - pop_d) : 6'd0;

    mem.we = mem.we & accept_i;
    mem.re = mem.re & accept_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= i2cmts_pkg::PhReady;
      target_q <= '0;
      len_q    <= i2cmts_pkg::CountW'(1);
      sp_q     <= '0;
      last_q   <= 1'b0;
      rc_q     <= '0;
      pop_q    <= '0;
      err_q    <= i2cmts_pkg::ErrNone;
    end else if (accept_i) begin
      phase_q  <= phase_d;
      target_q <= target_d;
      len_q    <= len_d;
      sp_q     <= sp_d;
      last_q   <= last_d;
      rc_q     <= rc_d;
      pop_q    <= pop_d;
      err_q    <= err_d;
    end
  end

  assign dec_o = dec;
  assign mem_o = mem;

endmodule
